FILE: sv/cdd_pkg.sv
`timescale 1ns / 1ps

package cdd_pkg;

  localparam int unsigned MaxYear  = 9999;
  localparam int unsigned Recip25  = 41944;  // ceil(2^20 / 25), exact for 14-bit years
  localparam int unsigned Recip25W = 16;
  localparam int unsigned RecipSh  = 20;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 22;
  localparam int unsigned StepW  = 4;

  typedef logic [YearW-1:0]  year_t;
  typedef logic [MonthW-1:0] month_t;
  typedef logic [DayW-1:0]   day_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [StepW-1:0]  step_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ORDER   = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic {
    YSEL_START = 1'b0,
    YSEL_END   = 1'b1
  } year_sel_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET_LEAP_S,
    OP_SET_LEAP_E,
    OP_ADD_MONTH,
    OP_FINISH,
    OP_FAIL_DATE,
    OP_FAIL_ORDER
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_INVALID,
    C_AFTER,
    C_SAME_MONTH,
    C_NO_WRAP
  } cond_e;

  typedef struct packed {
    year_sel_e ysel;
    op_e       op;
    cond_e     cond;
    step_t     target;
  } ucode_t;

  typedef struct packed {
    logic      load;
    year_sel_e ysel;
    op_e       op;
  } ctrl_t;

  typedef struct packed {
    logic invalid;
    logic after;
    logic same_month;
    logic no_wrap;
  } flags_t;

  localparam step_t StepIdle      = 4'd0;
  localparam step_t StepLeapStart = 4'd1;
  localparam step_t StepLeapEnd   = 4'd2;
  localparam step_t StepLatchEnd  = 4'd3;
  localparam step_t StepCheckDate = 4'd4;
  localparam step_t StepCheckOrd  = 4'd5;
  localparam step_t StepLoop      = 4'd6;
  localparam step_t StepAddMonth  = 4'd7;
  localparam step_t StepNewYear   = 4'd8;
  localparam step_t StepNewLeap   = 4'd9;
  localparam step_t StepFinish    = 4'd10;
  localparam step_t StepFailDate  = 4'd11;
  localparam step_t StepFailOrd   = 4'd12;

  localparam month_t MonthJan = 4'd1;
  localparam month_t MonthFeb = 4'd2;
  localparam month_t MonthDec = 4'd12;

  function automatic ucode_t ucode_rom(input step_t a);
    ucode_t w;
    w = '{ysel: YSEL_START, op: OP_NONE, cond: C_ALWAYS, target: StepIdle};
    case (a)
      StepLeapStart: w = '{YSEL_START, OP_NONE,       C_NEVER,      StepIdle};
      StepLeapEnd:   w = '{YSEL_END,   OP_SET_LEAP_S, C_NEVER,      StepIdle};
      StepLatchEnd:  w = '{YSEL_START, OP_SET_LEAP_E, C_NEVER,      StepIdle};
      StepCheckDate: w = '{YSEL_START, OP_NONE,       C_INVALID,    StepFailDate};
      StepCheckOrd:  w = '{YSEL_START, OP_NONE,       C_AFTER,      StepFailOrd};
      StepLoop:      w = '{YSEL_START, OP_NONE,       C_SAME_MONTH, StepFinish};
      StepAddMonth:  w = '{YSEL_START, OP_ADD_MONTH,  C_NO_WRAP,    StepLoop};
      StepNewYear:   w = '{YSEL_START, OP_NONE,       C_NEVER,      StepIdle};
      StepNewLeap:   w = '{YSEL_START, OP_SET_LEAP_S, C_ALWAYS,     StepLoop};
      StepFinish:    w = '{YSEL_START, OP_FINISH,     C_ALWAYS,     StepIdle};
      StepFailDate:  w = '{YSEL_START, OP_FAIL_DATE,  C_ALWAYS,     StepIdle};
      StepFailOrd:   w = '{YSEL_START, OP_FAIL_ORDER, C_ALWAYS,     StepIdle};
      default:       w = '{YSEL_START, OP_NONE,       C_ALWAYS,     StepIdle};
    endcase
    return w;
  endfunction

  function automatic day_t days_in_month(input month_t m, input logic leap);
    day_t d;
    case (m)
      MonthFeb:               d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic date_ok(input year_t y, input month_t m, input day_t d,
                                   input logic leap);
    logic ok;
    ok = (y != '0) && (y <= year_t'(MaxYear)) && (m >= MonthJan) && (m <= MonthDec) &&
         (d != '0) && (d <= days_in_month(m, leap));
    return ok;
  endfunction

endpackage

FILE: sv/cdd_leap.sv
`timescale 1ns / 1ps

module cdd_leap
  import cdd_pkg::*;
(
  input  logic  clk_i,
  input  year_t year_i,
  output logic  leap_o
);

  localparam int unsigned ProdW = YearW + Recip25W;
  localparam int unsigned QuotW = ProdW - RecipSh;

  year_t              year_q;
  logic [ProdW-1:0]   prod_q;
  logic [QuotW-1:0]   quot;
  year_t              times25;
  year_t              rem25;

  always_ff @(posedge clk_i) begin
    year_q <= year_i;
    prod_q <= ProdW'(year_i) * ProdW'(Recip25);
  end

  // year mod 25 from the registered reciprocal product
  assign quot    = prod_q[ProdW-1:RecipSh];
  assign times25 = YearW'({quot, 4'b0000}) + YearW'({quot, 3'b000}) + YearW'(quot);
  assign rem25   = year_q - times25;

  assign leap_o = (year_q[1:0] == 2'b00) && ((rem25 != '0) || (year_q[3:0] == 4'b0000));

endmodule

FILE: sv/cdd_datapath.sv
`timescale 1ns / 1ps

module cdd_datapath
  import cdd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  ctrl_t  ctrl_i,
  input  logic   cfg_we_i,
  input  logic   cfg_wdata_i,
  input  year_t  start_year_i,
  input  month_t start_month_i,
  input  day_t   start_day_i,
  input  year_t  end_year_i,
  input  month_t end_month_i,
  input  day_t   end_day_i,
  output flags_t flags_o,
  output logic   done_o,
  output count_t day_count_o,
  output logic [1:0] status_o
);

  year_t   cy_q, ey_q;
  month_t  cm_q, em_q;
  day_t    cd_q, ed_q;
  count_t  cnt_q;
  logic    leap_s_q, leap_e_q;
  logic    inc_q;
  logic    done_q;
  count_t  count_q;
  status_e status_q;
  logic    leap;
  year_t   leap_year;

  assign leap_year = (ctrl_i.ysel == YSEL_END) ? ey_q : cy_q;

  cdd_leap u_leap (
    .clk_i  (clk_i),
    .year_i (leap_year),
    .leap_o (leap)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        inc_q <= cfg_wdata_i;
      end
      done_q <= (ctrl_i.op == OP_FINISH) || (ctrl_i.op == OP_FAIL_DATE) ||
                (ctrl_i.op == OP_FAIL_ORDER);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cy_q  <= start_year_i;
      cm_q  <= start_month_i;
      cd_q  <= start_day_i;
      ey_q  <= end_year_i;
      em_q  <= end_month_i;
      ed_q  <= end_day_i;
      cnt_q <= '0;
    end
    case (ctrl_i.op)
      OP_SET_LEAP_S: leap_s_q <= leap;
      OP_SET_LEAP_E: leap_e_q <= leap;
      OP_ADD_MONTH: begin
        cnt_q <= cnt_q + count_t'(days_in_month(cm_q, leap_s_q));
        if (cm_q == MonthDec) begin
          cm_q <= MonthJan;
          cy_q <= cy_q + year_t'(1);
        end else begin
          cm_q <= cm_q + month_t'(1);
        end
      end
      OP_FINISH: begin
        count_q  <= cnt_q + count_t'(ed_q) - count_t'(cd_q) + count_t'(inc_q);
        status_q <= ST_OK;
      end
      OP_FAIL_DATE: begin
        count_q  <= '0;
        status_q <= ST_INVALID;
      end
      OP_FAIL_ORDER: begin
        count_q  <= '0;
        status_q <= ST_ORDER;
      end
      default: ;
    endcase
  end

  assign flags_o.invalid    = !date_ok(cy_q, cm_q, cd_q, leap_s_q) ||
                              !date_ok(ey_q, em_q, ed_q, leap_e_q);
  assign flags_o.after      = {cy_q, cm_q, cd_q} > {ey_q, em_q, ed_q};
  assign flags_o.same_month = (cy_q == ey_q) && (cm_q == em_q);
  assign flags_o.no_wrap    = (cm_q != MonthDec);

  assign done_o      = done_q;
  assign day_count_o = count_q;
  assign status_o    = status_q;

endmodule

FILE: sv/cdd_sequencer.sv
`timescale 1ns / 1ps

module cdd_sequencer
  import cdd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  flags_t flags_i,
  output ctrl_t  ctrl_o,
  output logic   busy_o
);

  step_t  upc_q, upc_d;
  ucode_t uw;
  logic   take;

  assign uw = ucode_rom(upc_q);

  always_comb begin
    case (uw.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_INVALID:    take = flags_i.invalid;
      C_AFTER:      take = flags_i.after;
      C_SAME_MONTH: take = flags_i.same_month;
      C_NO_WRAP:    take = flags_i.no_wrap;
      default:      take = 1'b1;
    endcase

    if (upc_q == StepIdle) begin
      upc_d = start_i ? StepLeapStart : StepIdle;
    end else if (take) begin
      upc_d = uw.target;
    end else begin
      upc_d = upc_q + step_t'(1);
    end

    ctrl_o.load = (upc_q == StepIdle) && start_i;
    ctrl_o.ysel = uw.ysel;
    ctrl_o.op   = (upc_q == StepIdle) ? OP_NONE : uw.op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= StepIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign busy_o = (upc_q != StepIdle);

endmodule

FILE: sv/calendar_day_difference_unit.sv
`timescale 1ns / 1ps
// From accept to done_o, a valid ordered pair walks the month loop once per month boundary
// crossed and recomputes the start leap flag at each year boundary crossed. Invalid dates
// fail at the date check and reversed dates at the order check. One word at a time: busy_o
// is high until the result strobe; the next word can start in the cycle done_o is high.
// done_o is a one-cycle strobe; the receiver cannot stall. Reset clears include_end_day.
module calendar_day_difference_unit
  import cdd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  output logic         busy_o,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  input  logic [13:0]  start_year_i,
  input  logic [3:0]   start_month_i,
  input  logic [4:0]   start_day_i,
  input  logic [13:0]  end_year_i,
  input  logic [3:0]   end_month_i,
  input  logic [4:0]   end_day_i,
  output logic         done_o,
  output logic [21:0]  day_count_o,
  output logic [1:0]   status_o
);

  ctrl_t  ctrl;
  flags_t flags;

  cdd_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o)
  );

  cdd_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_year_i  (start_year_i),
    .start_month_i (start_month_i),
    .start_day_i   (start_day_i),
    .end_year_i    (end_year_i),
    .end_month_i   (end_month_i),
    .end_day_i     (end_day_i),
    .flags_o       (flags),
    .done_o        (done_o),
    .day_count_o   (day_count_o),
    .status_o      (status_o)
  );

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("accepted word did not start the sequence");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (day_count_o == '0))
    else $error("failed word returned a nonzero count");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while sequence still running");

endmodule

FILE: bench/tb_calendar_day_difference_unit.sv
`timescale 1ns / 1ps

module tb_calendar_day_difference_unit;
  import cdd_pkg::*;

  typedef struct {
    year_t  sy;
    month_t sm;
    day_t   sd;
    year_t  ey;
    month_t em;
    day_t   ed;
  } date_pair_t;

  typedef struct {
    count_t  days;
    status_e st;
  } span_word_t;

  localparam longint unsigned CountTop = (64'd1 << CountW) - 1;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         start_i       = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic         cfg_wdata_i   = 1'b0;
  logic [13:0]  start_year_i  = '0;
  logic [3:0]   start_month_i = '0;
  logic [4:0]   start_day_i   = '0;
  logic [13:0]  end_year_i    = '0;
  logic [3:0]   end_month_i   = '0;
  logic [4:0]   end_day_i     = '0;
  logic         busy_o;
  logic         done_o;
  logic [21:0]  day_count_o;
  logic [1:0]   status_o;

  date_pair_t        pairs_to_send[$];
  span_word_t        spans_due[$];
  bit                end_day_on   = 1'b0;
  bit                took         = 1'b0;
  int                idle_left    = 0;
  int                burst_left   = 0;
  longint unsigned   cycle_budget = 0;
  longint unsigned   cycles       = 0;
  int                mismatches   = 0;
  int                words_seen   = 0;
  int                n_counted    = 0;
  int                n_reversed   = 0;
  int                n_rejected   = 0;
  int unsigned       widest_count = 0;

  calendar_day_difference_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_year_i (start_year_i),
    .start_month_i(start_month_i),
    .start_day_i  (start_day_i),
    .end_year_i   (end_year_i),
    .end_month_i  (end_month_i),
    .end_day_i    (end_day_i),
    .done_o       (done_o),
    .day_count_o  (day_count_o),
    .status_o     (status_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit leap_of(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    case (m)
      2:            return leap_of(y) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  function automatic bit date_good(input int unsigned y, input int unsigned m,
                                   input int unsigned d);
    return (y >= 1) && (y <= MaxYear) && (m >= 1) && (m <= 12) &&
           (d >= 1) && (d <= month_days(y, m));
  endfunction

  // days since 0001-01-00
  function automatic int unsigned serial_day(input int unsigned y, input int unsigned m,
                                             input int unsigned d);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (int unsigned k = 1; k < m; k++) n += month_days(y, k);
    return n + d;
  endfunction

  function automatic span_word_t date_span_of(input date_pair_t p, input bit with_end);
    span_word_t      r;
    int unsigned     a;
    int unsigned     b;
    longint unsigned c;
    r.days = '0;
    r.st   = ST_OK;
    if (!date_good(p.sy, p.sm, p.sd) || !date_good(p.ey, p.em, p.ed)) begin
      r.st = ST_INVALID;
    end else begin
      a = serial_day(p.sy, p.sm, p.sd);
      b = serial_day(p.ey, p.em, p.ed);
      if (a > b) begin
        r.st = ST_ORDER;
      end else begin
        c = longint'(b - a) + with_end;
        if (c > CountTop) c = CountTop;
        r.days = count_t'(c);
      end
    end
    return r;
  endfunction

  function automatic int draw_idle();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(4, 12);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic year_t pick_year();
    if ($urandom_range(0, 3) != 0) return year_t'($urandom_range(1, MaxYear));
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return 4;
      2:       return 100;
      3:       return 400;
      4:       return 1900;
      5:       return 2000;
      6:       return 2100;
      7:       return 2400;
      8:       return 9996;
      default: return 9999;
    endcase
  endfunction

  task automatic any_date(input year_t y, output month_t m, output day_t d);
    m = month_t'($urandom_range(1, 12));
    d = day_t'($urandom_range(1, month_days(y, m)));
  endtask

  task automatic queue_pair(input year_t sy, input month_t sm, input day_t sd,
                            input year_t ey, input month_t em, input day_t ed);
    date_pair_t  p;
    int unsigned span;
    p = '{sy, sm, sd, ey, em, ed};
    span = (sy > ey) ? sy - ey : ey - sy;
    // budget grows with the number of years the month loop crosses
    cycle_budget += 40 + 26 * (span + 1);
    pairs_to_send.push_back(p);
  endtask

  task automatic queue_random(input int n);
    year_t       sy, ey, ty;
    month_t      sm, em, tm;
    day_t        sd, ed, td;
    int          kind;
    int unsigned reach;
    bit          ordered;
    for (int i = 0; i < n; i++) begin
      kind  = $urandom_range(0, 99);
      sy    = pick_year();
      any_date(sy, sm, sd);
      reach = (kind >= 60 && kind < 66) ? $urandom_range(3, 300) : $urandom_range(0, 2);
      ey    = (sy + reach > MaxYear) ? year_t'(MaxYear) : year_t'(sy + reach);
      any_date(ey, em, ed);
      if (kind < 76) begin
        // ordered for most, reversed for kinds 66..75
        ordered = serial_day(sy, sm, sd) <= serial_day(ey, em, ed);
        if ((kind < 66) != ordered) begin
          ty = sy; tm = sm; td = sd;
          sy = ey; sm = em; sd = ed;
          ey = ty; em = tm; ed = td;
        end
      end else if (kind < 88) begin
        case ($urandom_range(0, 5))
          0: sy = $urandom_range(0, 1) ? year_t'(0) : year_t'($urandom_range(MaxYear + 1, 16383));
          1: sm = $urandom_range(0, 1) ? month_t'(0) : month_t'($urandom_range(13, 15));
          2: sd = (month_days(sy, sm) == 31 || $urandom_range(0, 1)) ? day_t'(0) :
                  day_t'($urandom_range(month_days(sy, sm) + 1, 31));
          3: ey = $urandom_range(0, 1) ? year_t'(0) : year_t'($urandom_range(MaxYear + 1, 16383));
          4: em = $urandom_range(0, 1) ? month_t'(0) : month_t'($urandom_range(13, 15));
          default: ed = (month_days(ey, em) == 31 || $urandom_range(0, 1)) ? day_t'(0) :
                        day_t'($urandom_range(month_days(ey, em) + 1, 31));
        endcase
      end else begin
        sy = year_t'($urandom);  sm = month_t'($urandom); sd = day_t'($urandom);
        ey = year_t'($urandom);  em = month_t'($urandom); ed = day_t'($urandom);
      end
      queue_pair(sy, sm, sd, ey, em, ed);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pairs_to_send.size() != 0 || start_i || spans_due.size() != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_end_day(input bit v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    end_day_on  = v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  always @(negedge clk_i) begin : drive_pairs
    date_pair_t nxt;
    if (rst_ni && !(start_i && !took)) begin
      if (start_i) idle_left = draw_idle();
      if (idle_left > 0) begin
        idle_left--;
        start_i <= 1'b0;
      end else if (pairs_to_send.size() != 0) begin
        nxt = pairs_to_send.pop_front();
        start_year_i  <= nxt.sy;
        start_month_i <= nxt.sm;
        start_day_i   <= nxt.sd;
        end_year_i    <= nxt.ey;
        end_month_i   <= nxt.em;
        end_day_i     <= nxt.ed;
        start_i       <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watch_results
    span_word_t want;
    date_pair_t seen;
    if (rst_ni) begin
      if (done_o) begin
        if (spans_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result word with nothing pending: day_count %0d status %0d",
                     day_count_o, status_o);
        end else begin
          want = spans_due.pop_front();
          words_seen++;
          case (want.st)
            ST_OK:    n_counted++;
            ST_ORDER: n_reversed++;
            default:  n_rejected++;
          endcase
          if (want.st == ST_OK && want.days > widest_count) widest_count = want.days;
          if (day_count_o !== want.days || status_o !== want.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word %0d: day_count exp %0d got %0d, status exp %0d got %0d",
                       words_seen, want.days, day_count_o, want.st, status_o);
          end
        end
      end
      took <= start_i && !busy_o;
      if (start_i && !busy_o) begin
        seen = '{start_year_i, start_month_i, start_day_i, end_year_i, end_month_i, end_day_i};
        spans_due.push_back(date_span_of(seen, end_day_on));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 4 * cycle_budget + 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    // include_end_day at its reset value
    queue_pair(2000, 2, 29, 2000, 2, 29);
    queue_pair(1, 1, 1, 1, 1, 2);
    queue_pair(1600, 1, 1, 2000, 1, 1);
    queue_pair(2024, 2, 28, 2024, 3, 1);
    queue_pair(1900, 2, 28, 1900, 3, 1);
    queue_pair(2000, 2, 28, 2000, 3, 1);
    queue_pair(1999, 12, 31, 2000, 1, 1);
    queue_pair(2000, 1, 2, 2000, 1, 1);
    queue_pair(9999, 12, 31, 1, 1, 1);
    queue_pair(2000, 0, 1, 2000, 1, 1);
    queue_pair(2000, 1, 1, 2000, 13, 1);
    queue_pair(2000, 15, 31, 2001, 1, 1);
    queue_pair(2000, 1, 0, 2000, 1, 5);
    queue_pair(2001, 4, 31, 2001, 5, 1);
    queue_pair(2000, 2, 30, 2000, 3, 1);
    queue_pair(1900, 2, 29, 1900, 3, 1);
    queue_pair(0, 1, 1, 1, 1, 1);
    queue_pair(1, 1, 1, 10000, 1, 1);
    queue_pair(9999, 12, 31, 16383, 15, 31);
    queue_pair(9999, 12, 31, 0, 1, 1);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    set_end_day(1'b1);
    queue_pair(1, 1, 1, 1, 1, 1);
    queue_pair(1, 1, 1, 9999, 12, 31);
    queue_pair(2000, 1, 2, 2000, 1, 1);
    queue_pair(2000, 4, 31, 2000, 5, 1);
    queue_pair(2023, 12, 31, 2024, 3, 1);
    wait_drained();

    set_end_day(1'b0);
    queue_random(50);
    wait_drained();

    set_end_day(1'b1);
    queue_random(50);
    wait_drained();

    repeat (50) @(posedge clk_i);
    $display("%0d date pairs in %0d cycles: %0d counted, %0d reversed, %0d rejected",
             words_seen, cycles, n_counted, n_reversed, n_rejected);
    $display("end day counted off and on; widest span %0d days; %0d mismatches",
             widest_count, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: calendar_day_difference_unit.f
sv/cdd_pkg.sv
sv/cdd_leap.sv
sv/cdd_datapath.sv
sv/cdd_sequencer.sv
sv/calendar_day_difference_unit.sv
bench/tb_calendar_day_difference_unit.sv
